### sv/nva_pkg.sv
package nva_pkg;

  localparam int unsigned MODE_W    = 1;
  localparam int unsigned CHANNEL_W = 4;
  localparam int unsigned NOTE_W    = 7;
  localparam int unsigned VOICE_W   = 3;
  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned ACTIVE_W  = 4;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register word indexes
  localparam logic REG_ACTIVE_VOICES = 1'b0;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

  localparam logic [MODE_W-1:0] MODE_OFF = 1'b0;
  localparam logic [MODE_W-1:0] MODE_ON  = 1'b1;

  localparam logic [ACTION_W-1:0] ACT_STARTED     = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_STOPPED     = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_ALREADY     = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_NOT_PLAYING = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_NO_FREE     = 3'd4;

endpackage

### sv/nva_if.sv
interface nva_in_if
  import nva_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [CHANNEL_W-1:0] channel;
  logic [NOTE_W-1:0]    note;

  modport source (output valid, output mode, output channel, output note, input ready);
  modport sink   (input valid, input mode, input channel, input note, output ready);
endinterface

interface nva_out_if
  import nva_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [VOICE_W-1:0]  voice;
  logic [NOTE_W-1:0]   note_out;
  logic [ACTION_W-1:0] action;

  modport source (output valid, output voice, output note_out, output action, input ready);
  modport sink   (input valid, input voice, input note_out, input action, output ready);
endinterface

### sv/note_voice_allocator_top.sv
// note voice allocator
//
// in_chan takes note events (mode, channel, note), one beat per event; out_chan
// gives one result beat per event: voice index, note and action code.
// cfg_* is an APB-style port holding active_voices at address 0.
//
// channel/note of each voice sit in a one-port-read synchronous memory; the busy
// flags sit in flops. an event scans the first n voices, one memory read per
// cycle, where n is active_voices capped at VOICES. the scan also records the
// lowest free voice, then the decide step loads the output register and, for a
// started voice, writes the memory. a new event is accepted only after the
// previous one has passed its decide step.
//
// reset frees every voice and sets active_voices to 8. a stalled receiver
// leaves the result in the output register; the next event is still accepted
// and scanned, and only its decide step waits until the register is taken.
module note_voice_allocator_top
  import nva_pkg::*;
#(
  parameter int unsigned VOICES = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  nva_in_if.sink                in_chan,
  nva_out_if.source             out_chan,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned CW = $clog2(VOICES + 1);
  localparam int unsigned EW = CHANNEL_W + NOTE_W;
  localparam logic [6:0]  VOICES_W7 = 7'(VOICES);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [ACTIVE_W-1:0]   active_r;
  logic [VOICES-1:0]     busy_r, busy_nxt;
  logic [MODE_W-1:0]     mode_r;
  logic [CHANNEL_W-1:0]  ch_r;
  logic [NOTE_W-1:0]     nt_r;
  logic [CW-1:0]         pool_n_r;
  logic [CW-1:0]         cnt_r;
  logic                  rd_v_r;
  logic [VW-1:0]         rd_idx_r;
  logic [EW-1:0]         rdata_r;
  logic                  hit_r, hit_nxt;
  logic [VW-1:0]         hit_idx_r, hit_idx_nxt;
  logic                  free_v_r, free_nxt;
  logic [VW-1:0]         free_idx_r, free_idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VOICE_W-1:0]    out_voice_r;
  logic [NOTE_W-1:0]     out_note_r;
  logic [ACTION_W-1:0]   out_action_r;

  logic [EW-1:0]         mem [VOICES];

  logic                  in_acc, issue, scan_done, out_free, decide;
  logic                  cfg_wr;
  logic [6:0]            act7, pool7;
  logic [VW-1:0]         ch_idx;
  logic                  pref_ok;
  logic                  mem_we;
  logic [VW-1:0]         mem_widx;
  logic [VOICE_W-1:0]    res_voice;
  logic [ACTION_W-1:0]   res_action;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_ACTIVE_VOICES)
                      ? {{(CFG_DATA_W-ACTIVE_W){1'b0}}, active_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
    end else if (cfg_wr && cfg_paddr[2] == REG_ACTIVE_VOICES) begin
      active_r <= cfg_pwdata[ACTIVE_W-1:0];
    end
  end

  assign act7  = {3'b000, active_r};
  assign pool7 = (act7 > VOICES_W7) ? VOICES_W7 : act7;

  // handshakes
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  assign out_chan.valid    = out_valid_r;
  assign out_chan.voice    = out_voice_r;
  assign out_chan.note_out = out_note_r;
  assign out_chan.action   = out_action_r;

  // scan control
  assign issue     = (state_r == S_SCAN) && (cnt_r < pool_n_r);
  assign scan_done = (state_r == S_SCAN) && !issue && !rd_v_r;
  assign decide    = (state_r == S_DECIDE) && out_free;

  // compare the entry read last cycle
  always_comb begin
    hit_nxt      = hit_r;
    hit_idx_nxt  = hit_idx_r;
    free_nxt     = free_v_r;
    free_idx_nxt = free_idx_r;
    if (rd_v_r) begin
      if (!hit_r && busy_r[rd_idx_r] && rdata_r == {ch_r, nt_r}) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = rd_idx_r;
      end
      if (!free_v_r && !busy_r[rd_idx_r]) begin
        free_nxt     = 1'b1;
        free_idx_nxt = rd_idx_r;
      end
    end
  end

  // decision
  assign ch_idx  = VW'(ch_r);
  assign pref_ok = (7'(ch_r) < 7'(pool_n_r)) && !busy_r[ch_idx];

  always_comb begin
    busy_nxt   = busy_r;
    mem_we     = 1'b0;
    mem_widx   = ch_idx;
    res_voice  = '0;
    res_action = ACT_NOT_PLAYING;
    if (mode_r == MODE_ON) begin
      if (hit_r) begin
        res_action = ACT_ALREADY;
      end else if (pref_ok || free_v_r) begin
        mem_widx   = pref_ok ? ch_idx : free_idx_r;
        mem_we     = decide;
        res_voice  = VOICE_W'(mem_widx);
        res_action = ACT_STARTED;
        if (decide) busy_nxt[mem_widx] = 1'b1;
      end else begin
        res_action = ACT_NO_FREE;
      end
    end else begin
      if (hit_r) begin
        res_voice  = VOICE_W'(hit_idx_r);
        res_action = ACT_STOPPED;
        if (decide) busy_nxt[hit_idx_r] = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_chan.ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (decide) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= '0;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
      cnt_r       <= '0;
      hit_r       <= 1'b0;
      free_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      rd_v_r      <= issue;
      if (in_acc) begin
        cnt_r    <= '0;
        hit_r    <= 1'b0;
        free_v_r <= 1'b0;
      end else begin
        if (issue) cnt_r <= cnt_r + CW'(1);
        hit_r    <= hit_nxt;
        free_v_r <= free_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r   <= in_chan.mode;
      ch_r     <= in_chan.channel;
      nt_r     <= in_chan.note;
      pool_n_r <= CW'(pool7);
    end
    rd_idx_r   <= cnt_r[VW-1:0];
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    if (decide) begin
      out_voice_r  <= res_voice;
      out_note_r   <= nt_r;
      out_action_r <= res_action;
    end
  end

  // voice table memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_widx] <= {ch_r, nt_r};
    if (issue) rdata_r <= mem[cnt_r[VW-1:0]];
  end

endmodule

### sv/nva_checker.sv
module nva_checker
  import nva_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [VOICE_W-1:0]    out_voice,
  input logic [ACTION_W-1:0]   out_action,
  input logic                  cfg_psel,
  input logic                  cfg_penable,
  input logic                  cfg_pwrite,
  input logic                  cfg_pready,
  input logic [CFG_ADDR_W-1:0] cfg_paddr,
  input logic [CFG_DATA_W-1:0] cfg_pwdata,
  input logic [CFG_DATA_W-1:0] cfg_prdata
);

  logic wr_active;
  assign wr_active = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                     && cfg_paddr[2] == REG_ACTIVE_VOICES;

  // a result beat waits until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // only a started or stopped result names a voice
  a_voice_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action != ACT_STARTED && out_action != ACT_STOPPED |-> out_voice == '0)
    else $error("voice field set without a voice change");

  // one event at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an event is in progress");

  // register reads back what was written
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    wr_active ##1 (cfg_paddr[2] == REG_ACTIVE_VOICES)
      |-> cfg_prdata[ACTIVE_W-1:0] == $past(cfg_pwdata[ACTIVE_W-1:0]))
    else $error("active_voices readback mismatch");

endmodule

bind note_voice_allocator_top nva_checker u_nva_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_voice   (out_chan.voice),
  .out_action  (out_chan.action),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_pready  (cfg_pready),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata)
);
